[design/tma_pkg.sv]
// package for the track met accumulator
// holds widths, register indexes, payload structs and constants; no dependencies
package tma_pkg;

    localparam int MAX_CANDIDATES_DEF = 4096;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VERTEX_X   = 3'd0,
        REG_VERTEX_Y   = 3'd1,
        REG_VERTEX_Z   = 3'd2,
        REG_DZ_CUT     = 3'd3,
        REG_PT_MIN     = 3'd4,
        REG_WEIGHT_MIN = 3'd5,
        REG_MODE       = 3'd6
    } t_reg_idx;

    localparam logic [1:0] MODE_WEIGHT_ONLY = 2'd1;
    localparam logic [1:0] MODE_DZ_ONLY     = 2'd2;

    typedef struct packed {
        logic               has_track;
        logic               is_charged;
        logic signed [19:0] mom_x;
        logic signed [19:0] mom_y;
        logic signed [19:0] mom_z;
        logic        [19:0] energy;
        logic        [18:0] trans_mom;
        logic signed [19:0] cand_vx;
        logic signed [19:0] cand_vy;
        logic signed [19:0] cand_vz;
        logic        [8:0]  track_weight;
        logic               is_last;
    } t_cand;

    typedef struct packed {
        logic signed [31:0] met_x;
        logic signed [31:0] met_y;
        logic signed [31:0] met_z;
        logic signed [31:0] met_energy;
        logic        [30:0] sum_et;
    } t_met;

    // classified beat handed from front to back
    typedef struct packed {
        logic               gate_ok;
        logic               w_ok;
        logic signed [20:0] dvx;
        logic signed [20:0] dvy;
        logic signed [20:0] dvz;
        logic signed [19:0] mom_x;
        logic signed [19:0] mom_y;
        logic signed [19:0] mom_z;
        logic        [19:0] energy;
        logic        [18:0] trans_mom;
        logic               is_last;
    } t_class;

endpackage

[design/tma_if.sv]
// valid/ready channel interface carrying one payload beat
// depends on nothing; payload type is a parameter
interface tma_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/track_met_accumulator.sv]
// top level of the track met accumulator: config registers, front, queue, back
// depends on tma_pkg, tma_if, tma_front, tma_queue, tma_back
// the back end takes a new candidate only after it has finished the previous one
// the front end and a 4-entry queue accept candidates while the back end works
// synchronous active-low reset clears sums, handshakes and loads register defaults
module track_met_accumulator import tma_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tma_if.sink                   s_cand,
    tma_if.source                 m_met,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic signed [19:0] r_vx, r_vy, r_vz;
    logic [18:0] r_dz_cut, r_pt_min;
    logic [8:0]  r_wmin;
    logic [1:0]  r_mode;

    logic   f_valid, f_ready, q_valid, q_ready;
    t_class f_class, q_class;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx <= '0; r_vy <= '0; r_vz <= '0;
            r_dz_cut <= 19'd1000; r_pt_min <= '0; r_wmin <= 9'd128; r_mode <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_VERTEX_X:   r_vx <= i_cfg_data;
                    REG_VERTEX_Y:   r_vy <= i_cfg_data;
                    REG_VERTEX_Z:   r_vz <= i_cfg_data;
                    REG_DZ_CUT:     r_dz_cut <= i_cfg_data[18:0];
                    REG_PT_MIN:     r_pt_min <= i_cfg_data[18:0];
                    REG_WEIGHT_MIN: r_wmin <= i_cfg_data[8:0];
                    REG_MODE:       r_mode <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    tma_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_cand.valid), .o_ready(s_cand.ready), .i_cand(s_cand.data),
        .i_vertex_x(r_vx), .i_vertex_y(r_vy), .i_vertex_z(r_vz),
        .i_pt_min(r_pt_min), .i_weight_min(r_wmin),
        .o_valid(f_valid), .i_ready(f_ready), .o_class(f_class)
    );

    tma_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_data(f_class),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_class)
    );

    tma_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_class(q_class),
        .i_dz_cut(r_dz_cut), .i_mode(r_mode),
        .o_valid(m_met.valid), .i_ready(m_met.ready), .o_met(m_met.data)
    );
endmodule

[design/tma_front.sv]
// front end: accepts candidates, applies gating and weight test, forms vertex offsets
// depends on tma_pkg
module tma_front import tma_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_cand              i_cand,
    input  logic signed [19:0] i_vertex_x,
    input  logic signed [19:0] i_vertex_y,
    input  logic signed [19:0] i_vertex_z,
    input  logic        [18:0] i_pt_min,
    input  logic        [8:0]  i_weight_min,
    output logic               o_valid,
    input  logic               i_ready,
    output t_class             o_class
);
    logic   r_valid;
    t_class r_class;
    t_class n_class;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_class = r_class;

    always_comb begin
        n_class.gate_ok   = i_cand.has_track && i_cand.is_charged
                            && (i_cand.trans_mom > i_pt_min);
        n_class.w_ok      = i_cand.track_weight > i_weight_min;
        n_class.dvx       = 21'(i_cand.cand_vx) - 21'(i_vertex_x);
        n_class.dvy       = 21'(i_cand.cand_vy) - 21'(i_vertex_y);
        n_class.dvz       = 21'(i_cand.cand_vz) - 21'(i_vertex_z);
        n_class.mom_x     = i_cand.mom_x;
        n_class.mom_y     = i_cand.mom_y;
        n_class.mom_z     = i_cand.mom_z;
        n_class.energy    = i_cand.energy;
        n_class.trans_mom = i_cand.trans_mom;
        n_class.is_last   = i_cand.is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_class <= n_class;
        end
    end
endmodule

[design/tma_queue.sv]
// small fifo decoupling front and back ends
// depends on tma_pkg
module tma_queue import tma_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_class i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_class o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    t_class         r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic           wr, rd;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
        if (wr) r_mem[r_wp] <= i_data;
    end
endmodule

[design/tma_back.sv]
// back end: dz test over a multiply pipeline, then saturating accumulation and output
// depends on tma_pkg
module tma_back import tma_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_class      i_class,
    input  logic [18:0] i_dz_cut,
    input  logic [1:0]  i_mode,
    output logic        o_valid,
    input  logic        i_ready,
    output t_met        o_met
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_M1, ST_M2, ST_M3, ST_ACC, ST_OUT
    } t_bstate;

    t_bstate r_state, n_state;
    t_class  r_c;
    logic signed [41:0] r_ax, r_ay;
    logic signed [38:0] r_pt2;
    logic signed [42:0] r_dot;
    logic signed [63:0] r_num, r_lhs;
    logic        [63:0] r_rhs;
    logic signed [32:0] r_acc_x, r_acc_y, r_acc_z, r_acc_e;
    logic        [31:0] r_acc_et;
    logic               r_out_valid;
    t_met               r_met;

    logic signed [63:0] diff, mag;
    logic               dz_ok, sel;
    logic        [31:0] et_sum;

    function automatic logic signed [32:0] sat_sub(input logic signed [32:0] a,
                                                   input logic signed [32:0] b);
        logic signed [33:0] s;
        s = 34'(a) - 34'(b);
        if (s > 34'sd2147483647) return 33'sd2147483647;
        if (s < -34'sd2147483648) return -33'sd2147483648;
        return s[32:0];
    endfunction

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_met   = r_met;

    always_comb begin
        diff  = r_lhs - r_num;
        mag   = diff[63] ? -diff : diff;
        dz_ok = $unsigned(mag) < r_rhs;
        et_sum = r_acc_et + 32'(r_c.trans_mom);
        case (i_mode)
            MODE_WEIGHT_ONLY: sel = r_c.w_ok;
            MODE_DZ_ONLY:     sel = dz_ok;
            default:          sel = r_c.w_ok || dz_ok;
        endcase
        sel = sel && r_c.gate_ok;
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_M1;
            ST_M1:   n_state = ST_M2;
            ST_M2:   n_state = ST_M3;
            ST_M3:   n_state = ST_ACC;
            ST_ACC:  n_state = r_c.is_last ? ST_OUT : ST_IDLE;
            ST_OUT:  if (!r_out_valid || i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_acc_z     <= '0;
            r_acc_e     <= '0;
            r_acc_et    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_ACC && sel) begin
                r_acc_x  <= sat_sub(r_acc_x, 33'(r_c.mom_x));
                r_acc_y  <= sat_sub(r_acc_y, 33'(r_c.mom_y));
                r_acc_z  <= sat_sub(r_acc_z, 33'(r_c.mom_z));
                r_acc_e  <= sat_sub(r_acc_e, 33'($signed({1'b0, r_c.energy})));
                r_acc_et <= et_sum[31] ? 32'h7FFFFFFF : et_sum;
            end
            if (r_state == ST_OUT && (!r_out_valid || i_ready)) begin
                r_out_valid      <= 1'b1;
                r_met.met_x      <= r_acc_x[31:0];
                r_met.met_y      <= r_acc_y[31:0];
                r_met.met_z      <= r_acc_z[31:0];
                r_met.met_energy <= r_acc_e[31:0];
                r_met.sum_et     <= r_acc_et[31] ? 31'h7FFFFFFF : r_acc_et[30:0];
                r_acc_x  <= '0;
                r_acc_y  <= '0;
                r_acc_z  <= '0;
                r_acc_e  <= '0;
                r_acc_et <= '0;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (r_state == ST_IDLE && i_valid) r_c <= i_class;
        case (r_state)
            ST_M1: begin
                r_ax  <= r_c.dvx * r_c.mom_x;
                r_ay  <= r_c.dvy * r_c.mom_y;
                r_pt2 <= $signed({1'b0, r_c.trans_mom}) * $signed({1'b0, r_c.trans_mom});
            end
            ST_M2: begin
                r_dot <= 43'(r_ax) + 43'(r_ay);
                r_lhs <= r_c.dvz * r_pt2;
                r_rhs <= 64'(i_dz_cut) * 64'(r_pt2[37:0]);
            end
            ST_M3: r_num <= 64'(r_dot) * 64'(r_c.mom_z);
            default: ;
        endcase
    end
endmodule
